### hdl/gpps_pkg.sv
package gpps_pkg;

    localparam int NUMBER_WIDTH = 16;
    localparam int SQ_WIDTH     = 2 * NUMBER_WIDTH;
    localparam int CNT_WIDTH    = $clog2(NUMBER_WIDTH);
    localparam int MIN_EVEN     = 4;
    localparam int FIRST_PRIME  = 2;

    typedef logic [NUMBER_WIDTH-1:0] t_number;
    typedef logic [SQ_WIDTH-1:0]     t_square;
    typedef logic [CNT_WIDTH-1:0]    t_count;
    typedef logic [1:0]              t_status;
    typedef logic [3:0]              t_upc;
    typedef logic [3:0]              t_uop;
    typedef logic [3:0]              t_ucond;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_ODD   = 2'd1;
    localparam t_status ST_SMALL = 2'd2;
    localparam t_status ST_NONE  = 2'd3;

    // Datapath operations.
    localparam t_uop OP_NOP       = 4'd0;
    localparam t_uop OP_ACCEPT    = 4'd1;
    localparam t_uop OP_SET_ODD   = 4'd2;
    localparam t_uop OP_SET_SMALL = 4'd3;
    localparam t_uop OP_INIT_P    = 4'd4;
    localparam t_uop OP_START_P   = 4'd5;
    localparam t_uop OP_DIV_START = 4'd6;
    localparam t_uop OP_DIV_STEP  = 4'd7;
    localparam t_uop OP_NEXT_D    = 4'd8;
    localparam t_uop OP_START_Q   = 4'd9;
    localparam t_uop OP_NEXT_P    = 4'd10;
    localparam t_uop OP_SET_OK    = 4'd11;
    localparam t_uop OP_EMIT      = 4'd12;

    // Jump conditions; the jump is taken when the condition holds.
    localparam t_ucond CD_NEVER      = 4'd0;
    localparam t_ucond CD_ALWAYS     = 4'd1;
    localparam t_ucond CD_NOT_ACCEPT = 4'd2;
    localparam t_ucond CD_N_ODD      = 4'd3;
    localparam t_ucond CD_N_LT4      = 4'd4;
    localparam t_ucond CD_P_GT_HALF  = 4'd5;
    localparam t_ucond CD_SQ_GT_C    = 4'd6;
    localparam t_ucond CD_DIV_BUSY   = 4'd7;
    localparam t_ucond CD_REM_ZERO   = 4'd8;
    localparam t_ucond CD_PHASE1     = 4'd9;
    localparam t_ucond CD_OUT_BUSY   = 4'd10;

    // Program addresses.
    localparam t_upc UA_WAIT     = 4'd0;
    localparam t_upc UA_ODD      = 4'd1;
    localparam t_upc UA_SMALL    = 4'd2;
    localparam t_upc UA_INIT     = 4'd3;
    localparam t_upc UA_LOOP_P   = 4'd4;
    localparam t_upc UA_TEST     = 4'd5;
    localparam t_upc UA_DIV      = 4'd6;
    localparam t_upc UA_NEXT_D   = 4'd7;
    localparam t_upc UA_BACK     = 4'd8;
    localparam t_upc UA_PRIME    = 4'd9;
    localparam t_upc UA_BACK2    = 4'd10;
    localparam t_upc UA_NOTPRIME = 4'd11;
    localparam t_upc UA_FOUND    = 4'd12;
    localparam t_upc UA_EMIT     = 4'd13;
    localparam t_upc UA_RETURN   = 4'd14;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_upc   target;
    } t_uword;

    function automatic t_uword ucode(input t_upc addr);
        t_uword w;
        case (addr)
            UA_WAIT:     w = '{OP_ACCEPT,    CD_NOT_ACCEPT, UA_WAIT};
            UA_ODD:      w = '{OP_SET_ODD,   CD_N_ODD,      UA_EMIT};
            UA_SMALL:    w = '{OP_SET_SMALL, CD_N_LT4,      UA_EMIT};
            UA_INIT:     w = '{OP_INIT_P,    CD_NEVER,      UA_WAIT};
            UA_LOOP_P:   w = '{OP_START_P,   CD_P_GT_HALF,  UA_EMIT};
            UA_TEST:     w = '{OP_DIV_START, CD_SQ_GT_C,    UA_PRIME};
            UA_DIV:      w = '{OP_DIV_STEP,  CD_DIV_BUSY,   UA_DIV};
            UA_NEXT_D:   w = '{OP_NEXT_D,    CD_REM_ZERO,   UA_NOTPRIME};
            UA_BACK:     w = '{OP_NOP,       CD_ALWAYS,     UA_TEST};
            UA_PRIME:    w = '{OP_START_Q,   CD_PHASE1,     UA_FOUND};
            UA_BACK2:    w = '{OP_NOP,       CD_ALWAYS,     UA_TEST};
            UA_NOTPRIME: w = '{OP_NEXT_P,    CD_ALWAYS,     UA_LOOP_P};
            UA_FOUND:    w = '{OP_SET_OK,    CD_NEVER,      UA_WAIT};
            UA_EMIT:     w = '{OP_EMIT,      CD_OUT_BUSY,   UA_EMIT};
            UA_RETURN:   w = '{OP_NOP,       CD_ALWAYS,     UA_WAIT};
            default:     w = '{OP_NOP,       CD_ALWAYS,     UA_WAIT};
        endcase
        return w;
    endfunction

endpackage

### hdl/goldbach_prime_pair_search.sv
// Run time is data dependent. Odd inputs and even inputs below four skip the search and go from
// their status step straight to the emit step. For an even input of four or more the block
// searches for the smallest prime p with n - p also prime, trying each trial divisor of a candidate
// in the bit-serial remainder unit. Throughput: one number at a time; after the result is
// registered, the sequencer passes its return step and then the wait step, where the next number is
// accepted. Reset: synchronous, active low; returns the sequencer to its wait step and clears o_out_valid.
module goldbach_prime_pair_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gpps_pkg::NUMBER_WIDTH-1:0] i_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gpps_pkg::NUMBER_WIDTH-1:0] o_smaller_prime,
    output logic [gpps_pkg::NUMBER_WIDTH-1:0] o_larger_prime,
    output logic [1:0]                    o_status
);
    import gpps_pkg::*;

    t_upc    r_pc, n_pc;
    logic    r_out_valid;
    t_number r_num, r_p, r_c, r_d, r_quo, r_rem;
    t_square r_sq;
    t_count  r_cnt;
    logic    r_phase;
    t_number r_small, r_large;
    t_status r_status;
    t_number r_out_small, r_out_large;
    t_status r_out_status;

    t_uword  w;
    logic    accept;
    logic    out_busy;
    logic    take;
    logic [NUMBER_WIDTH:0] trial;
    t_number diff;

    assign w        = ucode(r_pc);
    assign accept   = i_in_valid && !o_in_stall;
    assign out_busy = r_out_valid && i_out_stall;
    assign diff     = r_num - r_p;
    // One restoring division step: shift in the next dividend bit and subtract if it fits.
    assign trial    = {r_rem, r_quo[NUMBER_WIDTH-1]};

    assign o_in_stall      = (r_pc != UA_WAIT);
    assign o_out_valid     = r_out_valid;
    assign o_smaller_prime = r_out_small;
    assign o_larger_prime  = r_out_large;
    assign o_status        = r_out_status;

    always_comb begin
        case (w.cond)
            CD_NEVER:      take = 1'b0;
            CD_ALWAYS:     take = 1'b1;
            CD_NOT_ACCEPT: take = !accept;
            CD_N_ODD:      take = r_num[0];
            CD_N_LT4:      take = (r_num < NUMBER_WIDTH'(MIN_EVEN));
            CD_P_GT_HALF:  take = (r_p > (r_num >> 1));
            CD_SQ_GT_C:    take = (r_sq > SQ_WIDTH'(r_c));
            CD_DIV_BUSY:   take = (r_cnt != CNT_WIDTH'(NUMBER_WIDTH - 1));
            CD_REM_ZERO:   take = (r_rem == '0);
            CD_PHASE1:     take = r_phase;
            CD_OUT_BUSY:   take = out_busy;
            default:       take = 1'b1;
        endcase
        n_pc = take ? w.target : r_pc + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= UA_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w.op == OP_EMIT && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (w.op)
            OP_ACCEPT: begin
                if (accept) begin
                    r_num <= i_number;
                end
                r_small <= '0;
                r_large <= '0;
            end
            OP_SET_ODD:   r_status <= ST_ODD;
            OP_SET_SMALL: r_status <= ST_SMALL;
            OP_INIT_P: begin
                r_status <= ST_NONE;
                r_p      <= NUMBER_WIDTH'(FIRST_PRIME);
            end
            OP_START_P, OP_START_Q: begin
                r_c     <= (w.op == OP_START_P) ? r_p : diff;
                r_phase <= (w.op == OP_START_Q);
                r_d     <= NUMBER_WIDTH'(FIRST_PRIME);
                r_sq    <= SQ_WIDTH'(FIRST_PRIME * FIRST_PRIME);
            end
            OP_DIV_START: begin
                r_quo <= r_c;
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV_STEP: begin
                r_quo <= r_quo << 1;
                r_cnt <= r_cnt + 1'b1;
                if (trial >= {1'b0, r_d}) begin
                    r_rem <= NUMBER_WIDTH'(trial - {1'b0, r_d});
                end else begin
                    r_rem <= NUMBER_WIDTH'(trial);
                end
            end
            OP_NEXT_D: begin
                // (d + 1)^2 = d^2 + 2d + 1 keeps the bound test free of a multiplier.
                r_d  <= r_d + 1'b1;
                r_sq <= r_sq + SQ_WIDTH'({r_d, 1'b1});
            end
            OP_NEXT_P: r_p <= r_p + 1'b1;
            OP_SET_OK: begin
                r_status <= ST_OK;
                r_small  <= r_p;
                r_large  <= diff;
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    r_out_small  <= r_small;
                    r_out_large  <= r_large;
                    r_out_status <= r_status;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### hdl/gpps_checker.sv
module gpps_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [gpps_pkg::NUMBER_WIDTH-1:0] i_number,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [gpps_pkg::NUMBER_WIDTH-1:0] o_smaller_prime,
    input logic [gpps_pkg::NUMBER_WIDTH-1:0] o_larger_prime,
    input logic [1:0]                    o_status
);
    import gpps_pkg::*;

    // A stalled result must stay on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_smaller_prime)
            && $stable(o_larger_prime) && $stable(o_status))
        else $error("stalled result changed");

    // Only a found pair carries nonzero primes.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_smaller_prime == '0 && o_larger_prime == '0)
        else $error("prime fields nonzero without a pair");

    // A found pair is ordered and starts at the first prime.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK |->
            o_smaller_prime <= o_larger_prime && o_smaller_prime >= NUMBER_WIDTH'(FIRST_PRIME))
        else $error("pair out of order");

    // After reset the block is empty and ready for a transfer.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("bad state after reset");

endmodule

bind goldbach_prime_pair_search gpps_checker u_gpps_checker (.*);

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import gpps_pkg::*;

    localparam int CLK_PERIOD  = 20;
    // Far above the slowest legal run of the whole test.
    localparam int CYCLE_LIMIT = 40_000_000;
    localparam int IDLE_PCT    = 16;
    localparam int TAIL_CYCLES = 100;

    typedef struct {
        t_number smaller;
        t_number larger;
        t_status status;
    } t_pair;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_stall;
    t_number i_number;
    logic    o_out_valid;
    logic    i_out_stall;
    t_number o_smaller_prime;
    t_number o_larger_prime;
    logic [1:0] o_status;

    t_pair expected_pairs[$];
    t_pair want_pair;
    int    mismatch_count = 0;
    int    cycle_count = 0;
    bit    steady_flow = 1'b0;

    goldbach_prime_pair_search dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_number       (i_number),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_smaller_prime(o_smaller_prime),
        .o_larger_prime (o_larger_prime),
        .o_status       (o_status)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic bit trial_prime(input int unsigned c);
        if (c < FIRST_PRIME) return 1'b0;
        for (int unsigned d = FIRST_PRIME; d * d <= c; d++) begin
            if (c % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Smallest p such that both p and n - p are prime.
    function automatic t_pair goldbach_pair(input t_number n);
        t_pair pair;
        int unsigned value;
        value = 32'(n);
        pair.smaller = '0;
        pair.larger  = '0;
        if (n[0]) begin
            pair.status = ST_ODD;
        end else if (value < MIN_EVEN) begin
            pair.status = ST_SMALL;
        end else begin
            pair.status = ST_NONE;
            for (int unsigned p = FIRST_PRIME; p <= value / 2; p++) begin
                if (trial_prime(p) && trial_prime(value - p)) begin
                    pair.smaller = t_number'(p);
                    pair.larger  = t_number'(value - p);
                    pair.status  = ST_OK;
                    break;
                end
            end
        end
        return pair;
    endfunction

    // Most numbers stay small so the trial division stays short; a few span the full width.
    function automatic t_number random_number();
        t_number n;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 65) n = t_number'($urandom_range(1023));
        else if (pick < 88) n = t_number'($urandom_range(16383));
        else n = t_number'($urandom_range(65535));
        if ($urandom_range(99) < 80) n[0] = 1'b0;
        return n;
    endfunction

    // Valid is left high after a transfer; the next call or a drain decides whether it drops.
    task automatic send_number(input t_number n);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_number   <= n;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_pairs.push_back(goldbach_pair(n));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pairs.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_odd_inputs();
        send_number(16'd1);
        send_number(16'd3);
        send_number(16'h8001);
        send_number(16'h7fff);
        send_number(16'hffff);
    endtask

    task automatic test_below_four();
        send_number(16'd0);
        send_number(16'd2);
    endtask

    task automatic test_small_evens();
        for (int n = 4; n <= 14; n += 2) send_number(t_number'(n));
    endtask

    task automatic test_wide_evens();
        send_number(16'hfffe);
        send_number(16'hfffc);
        send_number(16'h8000);
        send_number(16'haaaa);
        send_number(16'h5556);
    endtask

    task automatic test_steady_stream();
        steady_flow = 1'b1;
        for (int i = 0; i < 40; i++) send_number(random_number());
        drain_results();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_numbers();
        for (int i = 0; i < 260; i++) begin
            send_number(random_number());
            // Now and then the sender holds off until the block has emptied.
            if (i % 50 == 49) drain_results();
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pairs.size() == 0) begin
                $error("unexpected result transfer: status %0d", o_status);
                mismatch_count++;
            end else begin
                want_pair = expected_pairs.pop_front();
                if (o_smaller_prime !== want_pair.smaller) begin
                    $error("smaller_prime: expected %0d, got %0d",
                           want_pair.smaller, o_smaller_prime);
                    mismatch_count++;
                end
                if (o_larger_prime !== want_pair.larger) begin
                    $error("larger_prime: expected %0d, got %0d",
                           want_pair.larger, o_larger_prime);
                    mismatch_count++;
                end
                if (o_status !== want_pair.status) begin
                    $error("status: expected %0d, got %0d", want_pair.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_number    <= '0;
        i_out_stall <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_odd_inputs();
        test_below_four();
        test_small_evens();
        test_wide_evens();
        test_steady_stream();
        test_random_numbers();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pairs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
